// ----- design/dft_ramp_weighted_spectral_filter_top_macros.svh -----
// Assertion macros for the DFT ramp filter block.
// Included by modules that carry concurrent checks; no other dependency.
`ifndef DFT_RAMP_WEIGHTED_SPECTRAL_FILTER_TOP_MACROS_SVH
`define DFT_RAMP_WEIGHTED_SPECTRAL_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- design/drwsf_pkg.sv -----
// Shared types, constants and twiddle function for the DFT ramp filter.
// No dependencies.
package drwsf_pkg;

    localparam int unsigned TABLE_LOG2 = 6;

    // Phase of the MAC loop
    typedef enum logic [1:0] {
        PH_FWD = 2'd0,
        PH_INV = 2'd1
    } phase_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       clear;     // zero accumulators
        logic       mac;       // accumulate one product
        logic       phase;     // 0 forward, 1 inverse
        logic [5:0] row;       // outer index (k or i)
        logic [5:0] col;       // inner index (i or k)
        logic       wr_spec;   // finalize forward bin
        logic       emit;      // finalize output
        logic       last;
    } dp_cmd_t;

    // Quarter-wave cosine, Q1.15
    function automatic logic signed [16:0] quarter_cos(input logic [4:0] m);
        logic signed [16:0] r;
        unique case (m)
            5'd0: r = 17'sd32767;  5'd1: r = 17'sd32610;  5'd2: r = 17'sd32138;
            5'd3: r = 17'sd31357;  5'd4: r = 17'sd30274;  5'd5: r = 17'sd28899;
            5'd6: r = 17'sd27246;  5'd7: r = 17'sd25330;  5'd8: r = 17'sd23170;
            5'd9: r = 17'sd20788;  5'd10: r = 17'sd18205; 5'd11: r = 17'sd15447;
            5'd12: r = 17'sd12540; 5'd13: r = 17'sd9512;  5'd14: r = 17'sd6393;
            5'd15: r = 17'sd3212;  default: r = 17'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [16:0] cos_at(input logic [5:0] m);
        logic signed [16:0] r;
        if (m <= 6'd16)      r = quarter_cos(m[4:0]);
        else if (m <= 6'd32) r = -quarter_cos(5'(6'd32 - m));
        else if (m <= 6'd48) r = -quarter_cos(5'(m - 6'd32));
        else                 r = quarter_cos(5'(7'd64 - {1'b0, m}));
        return r;
    endfunction

endpackage

// ----- design/drwsf_ctrl.sv -----
// Controller: load counting and sequencing of both DFT passes.
// Depends on drwsf_pkg.
module drwsf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         lg,        // active log2 length
    input  logic               in_fire,
    input  logic               out_busy,  // output register full and not drained
    output logic               in_rdy,
    output logic [5:0]         load_addr,
    output drwsf_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_LOAD, ST_MAC, ST_FIN, ST_WAIT
    } state_t;

    state_t      state_reg;
    logic [6:0]  load_reg;
    logic        phase_reg;
    logic [6:0]  row_reg;
    logic [6:0]  col_reg;
    logic [6:0]  n;

    assign n         = 7'd1 << lg;
    assign in_rdy    = (state_reg == ST_LOAD);
    assign load_addr = load_reg[5:0];

    // Commands are combinational decodes of the registered counters and out_busy
    always_comb
    begin
        cmd         = '0;
        cmd.phase   = phase_reg;
        cmd.row     = row_reg[5:0];
        cmd.col     = col_reg[5:0];
        cmd.clear   = (state_reg == ST_MAC) && (col_reg == 7'd0);
        // the drain cycle (col == n) issues no product
        cmd.mac     = (state_reg == ST_MAC) && (col_reg < n);
        cmd.wr_spec = (state_reg == ST_FIN) && !phase_reg;
        cmd.emit    = (state_reg == ST_FIN) && phase_reg && !out_busy;
        cmd.last    = (row_reg == n - 7'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            load_reg  <= '0;
            phase_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (cfg_we)
                        load_reg <= '0;
                    else if (in_fire)
                    begin
                        if (load_reg + 7'd1 >= n)
                        begin
                            load_reg  <= '0;
                            state_reg <= ST_MAC;
                            phase_reg <= 1'b0;
                            row_reg   <= '0;
                            col_reg   <= '0;
                        end
                        else
                            load_reg <= load_reg + 7'd1;
                    end
                end
                ST_MAC:
                begin
                    // the extra col == n step lets the registered store read drain
                    if (col_reg == n)
                        state_reg <= ST_WAIT;
                    col_reg <= col_reg + 7'd1;
                end
                ST_WAIT:
                    state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (!phase_reg || !out_busy)
                    begin
                        col_reg <= '0;
                        if (row_reg == n - 7'd1)
                        begin
                            row_reg <= '0;
                            if (phase_reg)
                                state_reg <= ST_LOAD;
                            else
                            begin
                                phase_reg <= 1'b1;
                                state_reg <= ST_MAC;
                            end
                        end
                        else
                        begin
                            row_reg   <= row_reg + 7'd1;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

endmodule

// ----- design/drwsf_datapath.sv -----
// Datapath: sample and spectrum stores, complex MAC, rounding and output.
// Depends on drwsf_pkg.
module drwsf_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         lg,
    input  logic               in_fire,
    input  logic [5:0]         load_addr,
    input  logic [31:0]        in_data,
    input  drwsf_pkg::dp_cmd_t cmd,
    input  logic               out_take,
    output logic               out_full,
    output logic [31:0]        out_data,
    output logic               out_last
);

    logic [31:0]        sample_mem [64];
    logic [47:0]        spec_mem   [64];
    logic [31:0]        smp_rd_reg;
    logic [47:0]        spc_rd_reg;
    logic signed [16:0] c_reg, d_reg;
    logic               mac_v_reg, mac_ph_reg;
    logic signed [63:0] acc_r_reg, acc_i_reg;
    logic signed [40:0] pr_reg [4];
    logic               pv_reg;
    logic               out_full_reg, out_last_reg;
    logic [31:0]        out_data_reg;
    logic [5:0]         m;
    logic [11:0]        prod;
    logic [2:0]         sh;
    logic signed [23:0] wy_r, wy_i;

    // Twiddle phase: (row*col) << (6-lg), modulo 64
    assign prod = cmd.row * cmd.col;
    assign sh   = 3'(drwsf_pkg::TABLE_LOG2) - lg;
    assign m    = 6'(prod << sh);

    // Stores: write in load or finalize, registered read
    always_ff @(posedge clk)
    begin
        if (in_fire)
            sample_mem[load_addr] <= in_data;
        if (cmd.wr_spec)
            spec_mem[cmd.row] <= {wy_i, wy_r};
        smp_rd_reg <= sample_mem[cmd.col];
        spc_rd_reg <= spec_mem[cmd.col];
        c_reg      <= drwsf_pkg::cos_at(m);
        d_reg      <= cmd.phase ? -drwsf_pkg::cos_at(m + 6'd48)
                                : drwsf_pkg::cos_at(m + 6'd48);
    end

    // Product stage
    logic signed [23:0] a, b;
    always_comb
    begin
        if (mac_ph_reg)
        begin
            a = spc_rd_reg[23:0];
            b = spc_rd_reg[47:24];
        end
        else
        begin
            a = {{8{smp_rd_reg[15]}}, smp_rd_reg[15:0]};
            b = {{8{smp_rd_reg[31]}}, smp_rd_reg[31:16]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_v_reg  <= 1'b0;
            mac_ph_reg <= 1'b0;
            pv_reg     <= 1'b0;
        end
        else
        begin
            mac_v_reg  <= cmd.mac;
            mac_ph_reg <= cmd.phase;
            pv_reg     <= mac_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_reg[0] <= a * c_reg;
        pr_reg[1] <= b * d_reg;
        pr_reg[2] <= a * d_reg;
        pr_reg[3] <= b * c_reg;
    end

    // Accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_r_reg <= '0;
            acc_i_reg <= '0;
        end
        else if (cmd.clear)
        begin
            acc_r_reg <= '0;
            acc_i_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_r_reg <= acc_r_reg + 64'(pr_reg[0]) - 64'(pr_reg[1]);
            acc_i_reg <= acc_i_reg + 64'(pr_reg[2]) + 64'(pr_reg[3]);
        end
    end

    // Forward finalize: round to Q9.15, saturate, ramp weight
    function automatic logic signed [23:0] fwd_bin(input logic signed [63:0] v,
                                                   input logic [5:0] k,
                                                   input logic [2:0] l);
        logic signed [63:0] t, y, w;
        logic signed [31:0] p;
        t = (v + 64'sd16384) >>> 15;
        y = (t > 64'sd8388607) ? 64'sd8388607 : (t < -64'sd8388608 ? -64'sd8388608 : t);
        if (k != 6'd0)
        begin
            // signed 24 x 7 bit product, fits in 32 bits
            p = 32'(y) * $signed({26'd0, k});
            w = (64'(p) + (64'sd1 <<< (l - 3'd1))) >>> l;
            y = (w > 64'sd8388607) ? 64'sd8388607 : (w < -64'sd8388608 ? -64'sd8388608 : w);
        end
        return y[23:0];
    endfunction

    assign wy_r = fwd_bin(acc_r_reg, cmd.row, lg);
    assign wy_i = fwd_bin(acc_i_reg, cmd.row, lg);

    function automatic logic [15:0] out_val(input logic signed [63:0] v,
                                            input logic [2:0] l);
        logic [4:0]         s;
        logic signed [63:0] t;
        s = 5'd15 + 5'(l);
        t = (v + (64'sd1 <<< (s - 5'd1))) >>> s;
        t = (t > 64'sd32767) ? 64'sd32767 : (t < -64'sd32768 ? -64'sd32768 : t);
        return t[15:0];
    endfunction

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (cmd.emit)
            out_full_reg <= 1'b1;
        else if (out_take)
            out_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {out_val(acc_i_reg, lg), out_val(acc_r_reg, lg)};
            out_last_reg <= cmd.last;
        end
    end

    assign out_full = out_full_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

// ----- design/dft_ramp_weighted_spectral_filter_top.sv -----
// Top level of the DFT ramp filter: config register, controller, datapath.
// Depends on drwsf_pkg, drwsf_ctrl, drwsf_datapath and the macros header.
// A frame of n = 2^log2_size samples is loaded one per cycle; then a forward
// and an inverse direct DFT run on one complex MAC, bin by bin and output by
// output, each a MAC pass over n terms followed by a wait and a finalize step.
// Outputs leave through a one-entry register; input is not taken during compute.
`include "dft_ramp_weighted_spectral_filter_top_macros.svh"
module dft_ramp_weighted_spectral_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_real[15:0], sample_imag[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_real[15:0], out_imag[31:16]
    output logic        m_tlast
);

    logic [2:0]         lg_reg, lg;
    logic               in_fire, out_full;
    logic [5:0]         load_addr;
    drwsf_pkg::dp_cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lg_reg <= 3'd6;
        else if (cfg_we)
            lg_reg <= cfg_data;
    end

    // Clamp to 1..6
    assign lg = (lg_reg == 3'd0) ? 3'd1 : ((lg_reg == 3'd7) ? 3'd6 : lg_reg);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_full;

    drwsf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .lg(lg), .in_fire(in_fire),
        .out_busy(out_full && !m_tready), .in_rdy(s_tready),
        .load_addr(load_addr), .cmd(cmd)
    );

    drwsf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .lg(lg), .in_fire(in_fire),
        .load_addr(load_addr), .in_data(s_tdata), .cmd(cmd),
        .out_take(m_tready), .out_full(out_full), .out_data(m_tdata),
        .out_last(m_tlast)
    );

    `ASSERT_IMPL(a_no_ready_while_out, clk, rst_n, (m_tvalid && !m_tready) |-> !cmd.emit)
    `ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, cmd.emit, m_tvalid)
    `ASSERT_IMPL(a_no_load_in_compute, clk, rst_n, cmd.mac |-> !s_tready)

endmodule

// ----- test/tb.sv -----
// Testbench for the DFT ramp filter top: frames of complex samples in, filtered frames out.
// Depends on dft_ramp_weighted_spectral_filter_top; the expected frames come from a local
// fixed-point model of the forward DFT, ramp weighting and scaled inverse DFT.
`timescale 1ns / 100ps
module tb;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
    } filt_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_data = 3'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // model state
    logic [2:0]         size_reg;
    logic signed [15:0] frame_re [64];
    logic signed [15:0] frame_im [64];
    int unsigned        fill_count;
    filt_out_t          expected_q [$];

    int  errors;
    int  cycles;
    bit  idle_on;
    bit  quiet_tail;

    always #2 clk = ~clk;

    dft_ramp_weighted_spectral_filter_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    function automatic longint twiddle_cos(int unsigned m);
        int unsigned q;
        int          tab [17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                                  23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
        q = m & 63;
        if (q <= 16) return tab[q];
        if (q <= 32) return -tab[32 - q];
        if (q <= 48) return -tab[q - 32];
        return tab[64 - q];
    endfunction

    function automatic longint round_shr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned eff_log2();
        if (size_reg < 1) return 1;
        if (size_reg > 6) return 6;
        return size_reg;
    endfunction

    // Filter one full frame and queue the n expected outputs
    task automatic filter_frame(int unsigned lg);
        int unsigned n;
        int unsigned stride;
        longint      spec_re [64];
        longint      spec_im [64];
        longint      acc_re, acc_im, c, d, y;
        filt_out_t   o;
        n = 1 << lg;
        stride = 64 >> lg;
        for (int k = 0; k < n; k++)
        begin
            acc_re = 0;
            acc_im = 0;
            for (int i = 0; i < n; i++)
            begin
                c = twiddle_cos(i * k * stride);
                d = twiddle_cos(i * k * stride + 48);
                acc_re += frame_re[i] * c - frame_im[i] * d;
                acc_im += frame_re[i] * d + frame_im[i] * c;
            end
            y = clip(round_shr(acc_re, 15), -8388608, 8388607);
            if (k != 0) y = clip(round_shr(y * k, lg), -8388608, 8388607);
            spec_re[k] = y;
            y = clip(round_shr(acc_im, 15), -8388608, 8388607);
            if (k != 0) y = clip(round_shr(y * k, lg), -8388608, 8388607);
            spec_im[k] = y;
        end
        for (int i = 0; i < n; i++)
        begin
            acc_re = 0;
            acc_im = 0;
            for (int k = 0; k < n; k++)
            begin
                c = twiddle_cos(i * k * stride);
                d = -twiddle_cos(i * k * stride + 48);
                acc_re += spec_re[k] * c - spec_im[k] * d;
                acc_im += spec_re[k] * d + spec_im[k] * c;
            end
            o.re = 16'(clip(round_shr(acc_re, 15 + lg), -32768, 32767));
            o.im = 16'(clip(round_shr(acc_im, 15 + lg), -32768, 32767));
            o.last = (i == n - 1);
            expected_q.push_back(o);
        end
    endtask

    task automatic model_sample(logic [15:0] re, logic [15:0] im);
        frame_re[fill_count & 63] = re;
        frame_im[fill_count & 63] = im;
        fill_count++;
        if (fill_count >= (1 << eff_log2()))
        begin
            fill_count = 0;
            filter_frame(eff_log2());
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // Send one sample request; idle gaps before it at random
    task automatic send_sample(logic [15:0] re, logic [15:0] im);
        if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {im, re};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        model_sample(re, im);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Register write while idle; drops partial frame
    task automatic write_size(logic [2:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        size_reg = v;
        fill_count = 0;
    endtask

    task automatic send_frames(int frames, int mode);
        logic [15:0] re, im;
        for (int f = 0; f < frames; f++)
            for (int i = 0; i < (1 << eff_log2()); i++)
            begin
                case (mode)
                    0: begin re = 16'h7fff; im = 16'h7fff; end
                    1: begin re = 16'h8000; im = 16'h8000; end
                    2: begin re = (i[0]) ? 16'h8000 : 16'h7fff; im = ~re; end
                    default: begin re = 16'($urandom); im = 16'($urandom); end
                endcase
                send_sample(re, im);
            end
    endtask

    task automatic test_extremes();
        write_size(3'd2);
        send_frames(1, 0);
        send_frames(1, 1);
        send_frames(1, 2);
        write_size(3'd1);
        send_frames(1, 2);
        send_frames(1, 0);
    endtask

    task automatic test_out_of_range_sizes();
        write_size(3'd0);
        send_frames(1, 3);
        write_size(3'd7);
        send_frames(1, 3);
    endtask

    // Partial frame is dropped by a register write
    task automatic test_partial_drop();
        write_size(3'd3);
        send_sample(16'h1234, 16'h8765);
        send_sample(16'h7fff, 16'h0001);
        write_size(3'd2);
        send_frames(1, 3);
    endtask

    task automatic test_random_sizes();
        int lg;
        for (int r = 0; r < 14; r++)
        begin
            lg = $urandom_range(1, 4);
            write_size(3'(lg));
            send_frames($urandom_range(1, 3), 3);
            if (r == 5) wait_drained();
        end
        write_size(3'd6);
        send_frames(1, 3);
        write_size(3'd5);
        send_frames(1, 3);
    endtask

    task automatic test_no_idle_tail();
        wait_drained();
        quiet_tail = 1'b1;
        write_size(3'd3);
        send_frames(3, 3);
    endtask

    // Output side: random stalls unless quiet_tail is set, compare each output with the oldest expectation
    always @(negedge clk)
        m_tready <= (quiet_tail || !idle_on) ? 1'b1 : ($urandom_range(0, 3) != 0);

    always @(posedge clk)
    begin
        filt_out_t w;
        cycles++;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report("unexpected output", {m_tlast, m_tdata[30:0]}, 32'd0);
            else
            begin
                w = expected_q.pop_front();
                if (m_tdata[15:0] !== w.re) report("out_real", m_tdata[15:0], w.re);
                if (m_tdata[31:16] !== w.im) report("out_imag", m_tdata[31:16], w.im);
                if (m_tlast !== w.last) report("out_last", m_tlast, w.last);
            end
        end
        if (cycles > 1500000)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        idle_on = 1'b1;
        quiet_tail = 1'b0;
        size_reg = 3'd6;
        fill_count = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_frames(1, 3);
        test_extremes();
        test_out_of_range_sizes();
        test_partial_drop();
        test_random_sizes();
        test_no_idle_tail();
        wait_drained();
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/drwsf_pkg.sv
design/drwsf_ctrl.sv
design/drwsf_datapath.sv
design/dft_ramp_weighted_spectral_filter_top.sv
test/tb.sv
